@@ rtl/core/ptp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptp_pkg: shared types, constants and helpers
// Sizes, register indexes and saturating arithmetic for the particle pool.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int PARTICLES = 32;
  localparam int SLOT_W    = $clog2(PARTICLES);
  localparam int COORD_W   = 32;
  localparam int VEC_W     = 3 * COORD_W;
  localparam int LIFE_W    = 16;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 66;
  localparam int THR_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_LENGTH = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic [LIFE_W-1:0] LIFETIME_RST     = 16'd16384;
  localparam logic [CFG_W-1:0]  TRAIL_LENGTH_RST = 16'd15;

  typedef logic [PARTICLES-1:0] slot_mask_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } slot_pick_t;

  // Lowest set bit of a slot mask.
  function automatic slot_pick_t first_set(input slot_mask_t m);
    slot_pick_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = PARTICLES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r.found = 1'b1;
        r.idx   = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  // Signed add clamped to the 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/ptp_ram.sv @@
// ----------------------------------------------------------------------------
// ptp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ptp_mul.sv @@
// ----------------------------------------------------------------------------
// ptp_mul: shared signed multiplier
// Registered 34x34 signed product used for steps, squares and the threshold.
// ----------------------------------------------------------------------------
module ptp_mul (
  input  logic                              clk,
  input  logic signed [ptp_pkg::MUL_W-1:0]  a,
  input  logic signed [ptp_pkg::MUL_W-1:0]  b,
  output logic signed [ptp_pkg::PROD_W-1:0] p
);
  import ptp_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/core/particle_trail_pool_update_core.sv @@
// ----------------------------------------------------------------------------
// particle_trail_pool_update_core: trail particle pool
// Emit claims the lowest dead slot; tick moves every live particle and
// returns one line per live slot, in slot order (one empty line if none).
// ----------------------------------------------------------------------------
// A tick request runs its setup, then works through each live particle in
// turn (read, load, three step multiplies, three squares, tail update); a
// stalled output holds the block. All multiplies go through one shared
// registered multiplier. in_stall stays high from the accepted request until
// its last result has been loaded into the output register. Configuration
// writes must only happen while the block is idle.
// ----------------------------------------------------------------------------
module particle_trail_pool_update_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptp_pkg::CFG_W-1:0]           cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [ptp_pkg::DT_W-1:0]            delta_time,
  input  logic signed [ptp_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [ptp_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [ptp_pkg::COORD_W-1:0]  pos_z,
  input  logic signed [ptp_pkg::COORD_W-1:0]  vel_x,
  input  logic signed [ptp_pkg::COORD_W-1:0]  vel_y,
  input  logic signed [ptp_pkg::COORD_W-1:0]  vel_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                line_valid,
  output logic [4:0]                          slot,
  output logic signed [ptp_pkg::COORD_W-1:0]  head_x,
  output logic signed [ptp_pkg::COORD_W-1:0]  head_y,
  output logic signed [ptp_pkg::COORD_W-1:0]  head_z,
  output logic signed [ptp_pkg::COORD_W-1:0]  tail_x,
  output logic signed [ptp_pkg::COORD_W-1:0]  tail_y,
  output logic signed [ptp_pkg::COORD_W-1:0]  tail_z,
  output logic                                accepted,
  output logic                                last
);
  import ptp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_EMIT  = 12'b000000000010,
    S_THR   = 12'b000000000100,
    S_SCAN  = 12'b000000001000,
    S_EMPTY = 12'b000000010000,
    S_RD    = 12'b000000100000,
    S_LD    = 12'b000001000000,
    S_MUL   = 12'b000010000000,
    S_STEP  = 12'b000100000000,
    S_SQ    = 12'b001000000000,
    S_ACC   = 12'b010000000000,
    S_TAIL  = 12'b100000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [LIFE_W-1:0] lifetime;
  logic [CFG_W-1:0]  trail_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime     <= LIFETIME_RST;
      trail_length <= TRAIL_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LIFETIME:     lifetime     <= cfg_data;
        REG_TRAIL_LENGTH: trail_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic [DT_W-1:0]           req_dt;
  logic [VEC_W-1:0]          req_pos;
  logic [VEC_W-1:0]          req_vel;

  // per-slot working registers
  logic [SLOT_W-1:0]         cur;
  slot_mask_t                alive;
  slot_mask_t                pend;
  logic [1:0]                axis;
  logic [2:0][COORD_W-1:0]   h;
  logic [2:0][COORD_W-1:0]   t;
  logic [2:0][COORD_W-1:0]   v;
  logic [2:0][COORD_W-1:0]   st;
  logic [LIFE_W-1:0]         life_cur;
  logic [ACC_W-1:0]          acc;
  logic [THR_W-1:0]          thr2;

  // RAM ports
  logic [VEC_W-1:0]          head_rd;
  logic [VEC_W-1:0]          tail_rd;
  logic [VEC_W-1:0]          vel_rd;
  logic [LIFE_W-1:0]         life_rd;
  logic                      emit_we;
  logic                      tick_we;
  logic [SLOT_W-1:0]         wr_slot;
  logic [VEC_W-1:0]          head_wd;
  logic [VEC_W-1:0]          tail_wd;
  logic [LIFE_W-1:0]         life_wd;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                      in_accept;
  logic                      out_free;
  slot_pick_t                free_pick;
  slot_pick_t                live_pick;
  slot_pick_t                next_pick;
  slot_mask_t                pend_next;
  logic                      trail_over;
  logic [2:0][COORD_W-1:0]   t_new;
  logic [LIFE_W-1:0]         life_new;
  logic signed [COORD_W:0]   diff;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign free_pick = first_set(~alive);
  assign live_pick = first_set(alive);
  assign pend_next = pend & ~(slot_mask_t'(1) << cur);
  assign next_pick = first_set(pend_next);

  // Head-tail difference needs 33 bits; square it on the shared multiplier.
  assign diff = {h[axis][COORD_W-1], h[axis]} - {t[axis][COORD_W-1], t[axis]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_THR: begin
        mul_a = MUL_W'(trail_length);
        mul_b = MUL_W'(trail_length);
      end
      S_MUL: begin
        mul_a = MUL_W'(signed'(v[axis]));
        mul_b = MUL_W'(req_dt);
      end
      S_SQ: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(diff);
      end
      default: ;
    endcase
  end

  ptp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Tail follows the head when the squared distance exceeds the threshold;
  // the wide accumulator also covers sums that pass 2^64.
  assign trail_over = acc > ACC_W'(thr2);
  assign life_new   = (life_cur > req_dt) ? (life_cur - req_dt) : '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_new[k] = trail_over ? sat_add(t[k], st[k]) : t[k];
    end
  end

  // RAM write muxing: emit fills a free slot (nothing when the pool is full),
  // tick writes back the moved particle
  assign emit_we = (state == S_EMIT) && out_free && free_pick.found;
  assign tick_we = (state == S_TAIL) && out_free;
  assign wr_slot = emit_we ? free_pick.idx : cur;
  assign head_wd = emit_we ? req_pos : h;
  assign tail_wd = emit_we ? req_pos : t_new;
  assign life_wd = emit_we ? lifetime : life_new;

  ptp_ram #(.WIDTH(VEC_W), .DEPTH(PARTICLES)) u_head_ram (
    .clk (clk), .we (emit_we || tick_we), .waddr (wr_slot), .wdata (head_wd),
    .raddr (cur), .rdata (head_rd)
  );

  ptp_ram #(.WIDTH(VEC_W), .DEPTH(PARTICLES)) u_tail_ram (
    .clk (clk), .we (emit_we || tick_we), .waddr (wr_slot), .wdata (tail_wd),
    .raddr (cur), .rdata (tail_rd)
  );

  ptp_ram #(.WIDTH(VEC_W), .DEPTH(PARTICLES)) u_vel_ram (
    .clk (clk), .we (emit_we), .waddr (wr_slot), .wdata (req_vel),
    .raddr (cur), .rdata (vel_rd)
  );

  ptp_ram #(.WIDTH(LIFE_W), .DEPTH(PARTICLES)) u_life_ram (
    .clk (clk), .we (emit_we || tick_we), .waddr (wr_slot), .wdata (life_wd),
    .raddr (cur), .rdata (life_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      alive <= '0;
      pend  <= '0;
      cur   <= '0;
      axis  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= (op == OP_EMIT) ? S_EMIT : S_THR;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            // a zero lifetime leaves the slot dead at once
            if (free_pick.found) begin
              alive[free_pick.idx] <= (lifetime != '0);
            end
            state <= S_IDLE;
          end
        end
        S_THR: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          pend <= alive;
          cur  <= live_pick.idx;
          state <= live_pick.found ? S_RD : S_EMPTY;
        end
        S_EMPTY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          axis  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (axis == 2'd2) begin
            axis  <= '0;
            state <= S_SQ;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_SQ: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (axis == 2'd2) begin
            state <= S_TAIL;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_SQ;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            alive[cur] <= (life_new != '0);
            pend       <= pend_next;
            cur        <= next_pick.idx;
            state      <= next_pick.found ? S_RD : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_dt  <= delta_time;
      req_pos <= {pos_z, pos_y, pos_x};
      req_vel <= {vel_z, vel_y, vel_x};
    end
    case (state)
      S_SCAN: begin
        thr2 <= {prod[31:0], 32'd0};
      end
      S_LD: begin
        h        <= head_rd;
        t        <= tail_rd;
        v        <= vel_rd;
        life_cur <= life_rd;
        acc      <= '0;
      end
      S_STEP: begin
        // floor of the Q16.32 product to Q16.16
        st[axis] <= prod[47:16];
        h[axis]  <= sat_add(h[axis], prod[47:16]);
      end
      S_ACC: begin
        acc <= acc + ACC_W'(unsigned'(prod[65:0]));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT || state == S_EMPTY || state == S_TAIL) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      case (state)
        S_EMIT: begin
          line_valid <= 1'b0;
          slot       <= free_pick.found ? 5'(free_pick.idx) : 5'd0;
          {head_z, head_y, head_x} <= '0;
          {tail_z, tail_y, tail_x} <= '0;
          accepted   <= free_pick.found;
          last       <= 1'b1;
        end
        S_EMPTY: begin
          line_valid <= 1'b0;
          slot       <= 5'd0;
          {head_z, head_y, head_x} <= '0;
          {tail_z, tail_y, tail_x} <= '0;
          accepted   <= 1'b0;
          last       <= 1'b1;
        end
        S_TAIL: begin
          line_valid <= 1'b1;
          slot       <= 5'(cur);
          {head_z, head_y, head_x} <= h;
          {tail_z, tail_y, tail_x} <= t_new;
          accepted   <= 1'b0;
          last       <= !next_pick.found;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sim/tb_particle_trail_pool_update_core.sv @@
// ----------------------------------------------------------------------------
// tb_particle_trail_pool_update_core: self-checking bench for the particle pool
// Drives emit and tick requests in random bursts against a randomly stalled
// result port. Predicts each line from its own copy of the pool and compares
// every result field by field, in order.
// ----------------------------------------------------------------------------
module tb_particle_trail_pool_update_core;
  import ptp_pkg::*;

  localparam int  MAX_LINES   = 32;
  localparam int  CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic                      op;
    logic [DT_W-1:0]           dt;
    logic signed [COORD_W-1:0] px, py, pz, vx, vy, vz;
  } pool_req_t;

  typedef struct packed {
    logic                      line_valid;
    logic [4:0]                slot;
    logic signed [COORD_W-1:0] hx, hy, hz, tx, ty, tz;
    logic                      accepted;
    logic                      last;
  } pool_line_t;

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall, op;
  logic [DT_W-1:0] delta_time;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic out_valid, out_stall, line_valid, accepted, last;
  logic [4:0] slot;
  logic signed [COORD_W-1:0] head_x, head_y, head_z, tail_x, tail_y, tail_z;

  particle_trail_pool_update_core i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .delta_time,
    .pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z,
    .out_valid, .out_stall, .line_valid, .slot,
    .head_x, .head_y, .head_z, .tail_x, .tail_y, .tail_z,
    .accepted, .last
  );

  // Requests waiting to be driven, and lines the pool should still return.
  pool_req_t  pending_reqs[$];
  pool_line_t expected_lines[$];
  int errors = 0;

  // Shadow copy of the pool and its registers.
  logic [LIFE_W-1:0]         life_mdl[PARTICLES];
  logic signed [COORD_W-1:0] head_mdl[PARTICLES][3];
  logic signed [COORD_W-1:0] tail_mdl[PARTICLES][3];
  logic signed [COORD_W-1:0] vel_mdl[PARTICLES][3];
  logic [CFG_W-1:0]          lifetime_mdl;
  logic [CFG_W-1:0]          trail_mdl;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Update the shadow pool for one accepted request and queue its lines.
  task automatic update_pool(input pool_req_t r);
    pool_line_t ln;
    longint stp[3];
    longint d;
    logic [65:0] dist2, ad, thr, thr2;
    int n;
    ln = '0;
    ln.last = 1'b1;
    if (r.op == OP_EMIT) begin
      for (int i = 0; i < PARTICLES; i++) begin
        if (life_mdl[i] == '0) begin
          head_mdl[i] = '{r.px, r.py, r.pz};
          tail_mdl[i] = '{r.px, r.py, r.pz};
          vel_mdl[i]  = '{r.vx, r.vy, r.vz};
          life_mdl[i] = lifetime_mdl;
          ln.slot     = 5'(i);
          ln.accepted = 1'b1;
          break;
        end
      end
      expected_lines = {expected_lines, ln};
      return;
    end
    n    = 0;
    thr  = 66'(trail_mdl) << 16;
    thr2 = thr * thr;
    for (int i = 0; i < PARTICLES; i++) begin
      if (life_mdl[i] == '0) continue;
      life_mdl[i] = (life_mdl[i] > r.dt) ? life_mdl[i] - r.dt : '0;
      dist2 = '0;
      for (int j = 0; j < 3; j++) begin
        // velocity times dt, floored back to Q16.16
        stp[j] = (longint'(vel_mdl[i][j]) * longint'({1'b0, r.dt})) >>> 16;
        head_mdl[i][j] = clamp32(longint'(head_mdl[i][j]) + stp[j]);
        d  = longint'(head_mdl[i][j]) - longint'(tail_mdl[i][j]);
        ad = 66'(d < 0 ? -d : d);
        dist2 += ad * ad;
      end
      // tail follows only once the trail is strictly longer than allowed
      if (dist2 > thr2) begin
        for (int j = 0; j < 3; j++)
          tail_mdl[i][j] = clamp32(longint'(tail_mdl[i][j]) + stp[j]);
      end
      if (n < MAX_LINES) begin
        ln = '0;
        ln.line_valid = 1'b1;
        ln.slot = 5'(i);
        {ln.hx, ln.hy, ln.hz} = {head_mdl[i][0], head_mdl[i][1], head_mdl[i][2]};
        {ln.tx, ln.ty, ln.tz} = {tail_mdl[i][0], tail_mdl[i][1], tail_mdl[i][2]};
        expected_lines = {expected_lines, ln};
        n++;
      end
    end
    if (n == 0) begin
      ln = '0;
      ln.last = 1'b1;
      expected_lines = {expected_lines, ln};
    end else begin
      expected_lines[expected_lines.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver: send requests in bursts, hold a request until it is taken.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      op         <= OP_TICK;
      delta_time <= '0;
      {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} <= '0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        pool_req_t r;
        r = pending_reqs.pop_front();
        {op, delta_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} <= r;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          // new burst; about a third of bursts come with no gap at all
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall: switch between free, light and heavy stalling.
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(10, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Monitor: predict on each accepted request, then check each accepted line.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        update_pool({op, delta_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z});
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected line: expected none, actual slot %0d", $time, slot);
          errors++;
        end else begin
          pool_line_t e;
          e = expected_lines.pop_front();
          check_field("line_valid", 32'(e.line_valid), 32'(line_valid));
          check_field("slot", 32'(e.slot), 32'(slot));
          check_field("head_x", e.hx, head_x);
          check_field("head_y", e.hy, head_y);
          check_field("head_z", e.hz, head_z);
          check_field("tail_x", e.tx, tail_x);
          check_field("tail_y", e.ty, tail_y);
          check_field("tail_z", e.tz, tail_z);
          check_field("accepted", 32'(e.accepted), 32'(accepted));
          check_field("last", 32'(e.last), 32'(last));
        end
      end
    end
  end

  // Hard stop if the pool hangs.
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_emit(input logic signed [31:0] px, py, pz, vx, vy, vz);
    pool_req_t r;
    r = {OP_EMIT, 16'($urandom), px, py, pz, vx, vy, vz};
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_tick(input logic [DT_W-1:0] dt);
    pool_req_t r;
    r = {OP_TICK, dt, 32'($urandom), 32'($urandom), 32'($urandom),
         32'($urandom), 32'($urandom), 32'($urandom)};
    pending_reqs = {pending_reqs, r};
  endtask

  // Mostly small positions and speeds so trails form; sometimes raw bits.
  function automatic logic signed [31:0] pick_coord(input int span);
    if ($urandom_range(0, 7) == 0) return 32'($urandom);
    return 32'($signed($urandom_range(0, 2 * span)) - span) * 65536
           + 32'($urandom_range(0, 65535));
  endfunction

  task automatic add_random(input int count, input int emit_pct);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < emit_pct)
        add_emit(pick_coord(1000), pick_coord(1000), pick_coord(1000),
                 pick_coord(60), pick_coord(60), pick_coord(60));
      else if ($urandom_range(0, 3) == 0)
        add_tick(16'($urandom));
      else
        add_tick(16'($urandom_range(0, 4096)));
    end
  endtask

  // Drain everything, then let the pool settle before touching registers.
  // Sample away from the active edge so the driver's updates have settled.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_lines.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_LIFETIME) lifetime_mdl = val;
    else trail_mdl = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] life, trail, input int count, pct);
    wait_idle();
    write_reg(REG_LIFETIME, life);
    write_reg(REG_TRAIL_LENGTH, trail);
    add_random(count, pct);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    lifetime_mdl = LIFETIME_RST;
    trail_mdl = TRAIL_LENGTH_RST;
    for (int i = 0; i < PARTICLES; i++) begin
      life_mdl[i] = '0;
      head_mdl[i] = '{0, 0, 0}; tail_mdl[i] = '{0, 0, 0}; vel_mdl[i] = '{0, 0, 0};
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tick, coordinate extremes, zero and full time steps.
    add_tick(16'd100);
    add_emit(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_emit(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_emit(32'sh00000000, 32'sh00000000, 32'sh00000000,
             32'sh00100000, 32'shfff00000, 32'sh00000000);
    add_tick(16'd0);
    add_tick(16'd1);
    add_tick(16'd8000);
    add_tick(16'hffff);      // saturates the extreme heads, kills everything
    add_tick(16'd50);        // empty again

    // Zero lifetime: the slot is claimed and dead at once; long trail.
    wait_idle();
    write_reg(REG_LIFETIME, 16'd0);
    write_reg(REG_TRAIL_LENGTH, 16'hffff);
    add_emit(32'sd65536, 32'sd0, -32'sd65536, 32'sd0, 32'sd0, 32'sd0);
    add_emit(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    add_tick(16'd1000);

    // Zero trail: any motion drags the tail along.
    wait_idle();
    write_reg(REG_LIFETIME, 16'hffff);
    write_reg(REG_TRAIL_LENGTH, 16'd0);
    add_emit(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0);
    add_tick(16'd0);
    add_tick(16'd32768);
    add_tick(16'hffff);

    // Random phases, one register setting each; the third one fills the pool.
    run_phase(LIFETIME_RST, TRAIL_LENGTH_RST, 60, 45);
    run_phase(16'($urandom_range(2000, 40000)), 16'($urandom_range(0, 20)), 60, 45);
    run_phase(16'hffff, 16'd3, 70, 75);
    run_phase(16'($urandom), 16'hffff, 30, 50);
    run_phase(16'd0, 16'($urandom), 12, 50);
    run_phase(16'hffff, 16'($urandom_range(0, 8)), 40, 30);

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
